/* rtl/alkd_pkg.sv */
// Shared types, constants and helpers for the ADC ladder keypad decoder.
// No dependencies; every other file in rtl/ but alkd_checker.sv imports this package.
`default_nettype none

package alkd_pkg;

  // Parameter defaults
  localparam int unsigned MAX_LEVELS_DEF  = 8;
  localparam int unsigned SAMPLE_BITS_DEF = 10;

  // Fixed field geometry
  localparam int unsigned THR_BITS   = 10;
  localparam int unsigned CNT_BITS   = 4;
  localparam int unsigned CODE_BITS  = 8;
  localparam int unsigned OUT_BITS   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CNT_BITS-1:0] COUNT_MAX   = 4'hF;
  localparam logic [OUT_BITS-1:0] NO_KEY_CODE = 16'hFFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOWER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_UPPER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_CODES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT     = 3'd6;

  // Reset values
  localparam logic [3:0]  RST_LEVEL_COUNT   = 4'd4;
  localparam logic [39:0] RST_THR_LOWER     = 40'hE0_2826_0C84;
  localparam logic [39:0] RST_THR_UPPER     = 40'h0;
  localparam logic [63:0] RST_KEY_CODES     = 64'hFFFF_FFFF_5A06_0746;
  localparam logic [9:0]  RST_TOLERANCE     = 10'd255;
  localparam logic [3:0]  RST_WINDOW_LENGTH = 4'd10;
  localparam logic [3:0]  RST_MIN_COUNT     = 4'd9;

  typedef struct packed {
    logic [3:0]  level_count;
    logic [39:0] thr_lower;
    logic [39:0] thr_upper;
    logic [63:0] key_codes;
    logic [9:0]  tolerance;
    logic [3:0]  window_length;
    logic [3:0]  min_count;
  } cfg_t;

  typedef struct packed {
    logic                 found;
    logic [CODE_BITS-1:0] code;
  } decision_t;

  // Threshold of one level; levels 0..3 live in the lower word
  function automatic logic [THR_BITS-1:0] thr_of(cfg_t c, logic [2:0] lvl);
    logic [39:0] word;
    word = lvl[2] ? c.thr_upper : c.thr_lower;
    return word[lvl[1:0]*THR_BITS +: THR_BITS];
  endfunction

  function automatic logic [CODE_BITS-1:0] key_of(cfg_t c, logic [2:0] lvl);
    return c.key_codes[lvl*CODE_BITS +: CODE_BITS];
  endfunction

endpackage

`default_nettype wire

/* rtl/adc_ladder_keypad_decoder_core.sv */
// Top level of the ADC ladder keypad decoder: config registers, input
// register, per-level counters and result register. Uses alkd_pkg,
// alkd_level_match and alkd_decide.
//
// Usage
//   s_axis carries one ADC sample per word (tdata). Each sample is matched to
//   the first level in use whose threshold is above it by at most the
//   tolerance; that level's 4-bit counter counts up and sticks at 15.
//   After window_length samples (0 acts as 1) one result word goes out on
//   m_axis: tuser = key found, tdata = key code byte (zero-extended) or
//   0xFFFF for no key. Counters and the sample count then clear.
//   Windows that are not yet complete produce no word.
// Throughput
//   One word per cycle sustained while no closing sample is held (see Stall).
//   A sample sits in the input register while the classify/count/decide
//   logic runs; for a closing sample the result register then loads, and
//   the result word goes out on m_axis from there.
// Stall
//   While a result waits on m_axis_tready, samples that do not close a window
//   keep flowing; a sample that closes a window holds in the input register
//   until the result register frees, and s_axis_tready drops behind it.
// Reset
//   rst_ni (async, active low) restores the register reset values, clears
//   counters, and empties both registers. Config writes (cfg_we_i) take
//   effect at the next edge and are meant for idle periods only.
`default_nettype none

module adc_ladder_keypad_decoder_core #(
  parameter int unsigned MAX_LEVELS  = alkd_pkg::MAX_LEVELS_DEF,
  parameter int unsigned SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write port
  input  logic                                   cfg_we_i,
  input  logic [alkd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [alkd_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // sample stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  // result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [alkd_pkg::OUT_BITS-1:0]          m_axis_tdata,   // [15:0] key_code
  output logic                                   m_axis_tuser    // [0] key_found
);
  import alkd_pkg::*;

  // ---------------- configuration registers ----------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_count   <= RST_LEVEL_COUNT;
      cfg_q.thr_lower     <= RST_THR_LOWER;
      cfg_q.thr_upper     <= RST_THR_UPPER;
      cfg_q.key_codes     <= RST_KEY_CODES;
      cfg_q.tolerance     <= RST_TOLERANCE;
      cfg_q.window_length <= RST_WINDOW_LENGTH;
      cfg_q.min_count     <= RST_MIN_COUNT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEVEL_COUNT:   cfg_q.level_count   <= cfg_wdata_i[3:0];
        REG_THR_LOWER:     cfg_q.thr_lower     <= cfg_wdata_i[39:0];
        REG_THR_UPPER:     cfg_q.thr_upper     <= cfg_wdata_i[39:0];
        REG_KEY_CODES:     cfg_q.key_codes     <= cfg_wdata_i;
        REG_TOLERANCE:     cfg_q.tolerance     <= cfg_wdata_i[9:0];
        REG_WINDOW_LENGTH: cfg_q.window_length <= cfg_wdata_i[3:0];
        REG_MIN_COUNT:     cfg_q.min_count     <= cfg_wdata_i[3:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // levels in use, clamped to what the hardware holds
  logic [3:0] levels;
  assign levels = (cfg_q.level_count > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : cfg_q.level_count;

  // ---------------- input register ----------------
  logic                   in_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   advance;

  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
  end

  // ---------------- classify and count ----------------
  logic [MAX_LEVELS-1:0]               hit;
  logic [MAX_LEVELS-1:0][CNT_BITS-1:0] counts_q;
  logic [MAX_LEVELS-1:0][CNT_BITS-1:0] counts_d;
  logic [3:0]                          sc_q;
  logic [3:0]                          sc_next;
  logic                                win_end;
  decision_t                           dec;

  alkd_level_match #(
    .MAX_LEVELS  (MAX_LEVELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_match (
    .cfg_i    (cfg_q),
    .levels_i (levels),
    .sample_i (sample_q),
    .hit_o    (hit)
  );

  // counts including the current sample; saturate at 15
  always_comb begin
    for (int j = 0; j < MAX_LEVELS; j++) begin
      counts_d[j] = (hit[j] && (counts_q[j] != COUNT_MAX)) ? counts_q[j] + 4'd1 : counts_q[j];
    end
  end

  // the sample that closes the window is counted before deciding
  alkd_decide #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_decide (
    .cfg_i    (cfg_q),
    .levels_i (levels),
    .counts_i (counts_d),
    .dec_o    (dec)
  );

  assign sc_next = sc_q + 4'd1;
  assign win_end = !(sc_next < cfg_q.window_length);

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign advance  = in_valid_q && (!win_end || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q     <= '0;
      counts_q <= '0;
    end else if (advance) begin
      if (win_end) begin
        sc_q     <= '0;
        counts_q <= '0;
      end else begin
        sc_q     <= sc_next;
        counts_q <= counts_d;
      end
    end
  end

  // ---------------- result register ----------------
  logic                out_valid_q;
  logic                key_found_q;
  logic [OUT_BITS-1:0] key_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && win_end) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && win_end) begin
      key_found_q <= dec.found;
      key_code_q  <= dec.found ? {8'h00, dec.code} : NO_KEY_CODE;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = key_code_q;
  assign m_axis_tuser  = key_found_q;

endmodule

`default_nettype wire

/* rtl/alkd_level_match.sv */
// Sample classifier: one-hot of the first level in use whose threshold sits
// above the sample by at most the tolerance. Uses alkd_pkg.
`default_nettype none

module alkd_level_match #(
  parameter int unsigned MAX_LEVELS  = alkd_pkg::MAX_LEVELS_DEF,
  parameter int unsigned SAMPLE_BITS = alkd_pkg::SAMPLE_BITS_DEF
) (
  input  alkd_pkg::cfg_t          cfg_i,
  input  logic [3:0]              levels_i,  // levels in use, already clamped
  input  logic [SAMPLE_BITS-1:0]  sample_i,
  output logic [MAX_LEVELS-1:0]   hit_o
);
  import alkd_pkg::*;

  localparam int unsigned CMP_W = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  logic [MAX_LEVELS-1:0] fit;

  always_comb begin
    logic [CMP_W-1:0] s_ext;
    logic [CMP_W-1:0] t_ext;
    logic [CMP_W-1:0] tol_ext;
    s_ext   = CMP_W'(sample_i);
    tol_ext = CMP_W'(cfg_i.tolerance);
    for (int j = 0; j < MAX_LEVELS; j++) begin
      t_ext  = CMP_W'(thr_of(cfg_i, 3'(j)));
      fit[j] = (4'(j) < levels_i) && (s_ext < t_ext) && ((t_ext - s_ext) <= tol_ext);
    end
  end

  // first fitting level wins
  always_comb begin
    logic taken;
    taken = 1'b0;
    hit_o = '0;
    for (int j = 0; j < MAX_LEVELS; j++) begin
      if (fit[j] && !taken) begin
        hit_o[j] = 1'b1;
        taken    = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/alkd_decide.sv */
// Window decision: first level in use whose count exceeds min_count,
// with its key code byte. Uses alkd_pkg.
`default_nettype none

module alkd_decide #(
  parameter int unsigned MAX_LEVELS = alkd_pkg::MAX_LEVELS_DEF
) (
  input  alkd_pkg::cfg_t                             cfg_i,
  input  logic [3:0]                                 levels_i,
  input  logic [MAX_LEVELS-1:0][alkd_pkg::CNT_BITS-1:0] counts_i,
  output alkd_pkg::decision_t                        dec_o
);
  import alkd_pkg::*;

  always_comb begin
    dec_o = '0;
    for (int j = 0; j < MAX_LEVELS; j++) begin
      if (!dec_o.found && (4'(j) < levels_i) && (counts_i[j] > cfg_i.min_count)) begin
        dec_o.found = 1'b1;
        dec_o.code  = key_of(cfg_i, 3'(j));
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/alkd_checker.sv */
// Port-level checks on the result stream of the keypad decoder, bound to
// adc_ladder_keypad_decoder_core. Depends only on its ports.
`default_nettype none

module alkd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // no-key word carries the no-key code
  a_no_key_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'hFFFF)
    else $error("no-key word without no-key code");

  // found key carries a zero-extended byte
  a_key_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:8] == 8'h00)
    else $error("key code wider than one byte");

  // nothing goes out once reset has been seen at an edge
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind adc_ladder_keypad_decoder_core alkd_checker u_alkd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
